// ===== hdl/sorted_top_k_tracker_macros.svh =====
// Assertion macros for the sorted top-k tracker checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef SORTED_TOP_K_TRACKER_MACROS_SVH
`define SORTED_TOP_K_TRACKER_MACROS_SVH

// Property checked on the rising clock edge, disabled while reset is held.
`define STKT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("stkt assertion failed");

// Same, but with no reset qualifier (for checks that must hold in reset too).
`define STKT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("stkt assertion failed");

`endif

// ===== hdl/stkt_pkg.sv =====
// Package for the sorted top-k tracker: field widths, codes, request and
// result types and the controller state type. No dependencies.
`default_nettype none

package stkt_pkg;

  localparam int unsigned MaxEntriesDefault = 16;
  localparam int unsigned DurBits           = 48;
  localparam int unsigned TagBits           = 32;
  localparam int unsigned CfgBits           = 5;

  localparam logic OpInsert   = 1'b0;
  localparam logic OpList     = 1'b1;
  localparam logic KindEvict  = 1'b0;
  localparam logic KindListed = 1'b1;

  typedef struct packed {
    logic               op;
    logic [TagBits-1:0] record_tag;
    logic [DurBits-1:0] record_duration;
  } in_req_t;

  typedef struct packed {
    logic               result_kind;
    logic [TagBits-1:0] out_tag;
    logic [DurBits-1:0] out_duration;
    logic               last_of_run;
  } out_rsp_t;

  typedef struct packed {
    logic [TagBits-1:0] tag;
    logic [DurBits-1:0] dur;
  } entry_t;

  typedef enum logic [1:0] {
    StIdle,
    StInsCmp,
    StInsPut,
    StList
  } state_e;

endpackage

`default_nettype wire

// ===== hdl/sorted_top_k_tracker.sv =====
// Sorted top-k tracker: entry memory, insertion walk and readout sequencer.
// Depends on stkt_pkg.
//
// Keeps up to keep_limit records sorted by duration, largest first, in one
// single-port-write, registered-read memory of MAX_ENTRIES entries. An insert
// into an empty list writes the head straight away. Otherwise it walks
// backwards from the tail: a first read of the tail, then one compare per
// entry, each smaller one moved down a slot, plus one more step when the new
// record lands at the head; the walk is set by the one read and one write per
// cycle of the memory, and at the tail of a full list it waits for a free
// output register. A readout streams one entry per cycle while the output is
// taken. An eviction is reported once per insert into a full list. The output
// register lets the next request be accepted while a result still waits. No
// clearing pass: entries beyond the fill count are never read.
`default_nettype none

module sorted_top_k_tracker
  import stkt_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire in_req_t            in_req_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output out_rsp_t                out_rsp_o,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgBits-1:0] cfg_data_i
);

  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CmpW = (CntW > CfgBits) ? CntW : CfgBits;

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] limit_q;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [TagBits-1:0] new_tag_q;
  logic [DurBits-1:0] new_dur_q;
  logic out_valid_q;
  out_rsp_t out_rsp_q, out_rsp_d;
  logic out_load, out_free;

  // entry memory
  entry_t mem_q [MAX_ENTRIES];
  entry_t rdata_q;
  logic rd_en, we;
  logic [IdxW-1:0] raddr, waddr;
  entry_t wdata;

  logic [CntW-1:0] idx_next;
  logic at_limit, smaller, accept;
  entry_t new_entry;
  logic [CntW-1:0] cnt_after_put;
  logic [CmpW-1:0] cfg_v;
  logic [CntW-1:0] limit_d;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem_q[raddr];
    end
  end

  assign accept    = in_valid_i && in_ready_o;
  assign out_free  = !out_valid_q || out_ready_i;
  assign idx_next  = CntW'(idx_q) + CntW'(1);
  assign at_limit  = (idx_next == limit_q);
  assign smaller   = (rdata_q.dur < new_dur_q);
  assign new_entry = '{tag: new_tag_q, dur: new_dur_q};
  assign cnt_after_put = (cnt_q < limit_q) ? cnt_q + CntW'(1) : cnt_q;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    rd_en     = 1'b0;
    raddr     = idx_q;
    we        = 1'b0;
    waddr     = idx_q;
    wdata     = rdata_q;
    out_load  = 1'b0;
    out_rsp_d = out_rsp_q;
    in_ready_o = (state_q == StIdle);

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (in_req_i.op == OpInsert) begin
            if (cnt_q == '0) begin
              we    = 1'b1;
              waddr = '0;
              wdata = '{tag: in_req_i.record_tag, dur: in_req_i.record_duration};
              cnt_d = CntW'(1);
            end else begin
              // start the walk at the tail
              rd_en   = 1'b1;
              raddr   = IdxW'(cnt_q - CntW'(1));
              idx_d   = IdxW'(cnt_q - CntW'(1));
              state_d = StInsCmp;
            end
          end else if (cnt_q != '0) begin
            rd_en   = 1'b1;
            raddr   = '0;
            idx_d   = '0;
            state_d = StList;
          end
        end
      end

      StInsCmp: begin
        // tail slot of a full list: needs the output register free
        if (!at_limit || out_free) begin
          if (at_limit) begin
            out_load  = 1'b1;
            out_rsp_d.result_kind  = KindEvict;
            out_rsp_d.out_tag      = smaller ? rdata_q.tag : new_tag_q;
            out_rsp_d.out_duration = smaller ? rdata_q.dur : new_dur_q;
            out_rsp_d.last_of_run  = 1'b1;
          end
          if (smaller) begin
            if (!at_limit) begin
              we    = 1'b1;
              waddr = IdxW'(idx_next);
              wdata = rdata_q;
            end
            if (idx_q == '0) begin
              state_d = StInsPut;
            end else begin
              idx_d = idx_q - IdxW'(1);
              rd_en = 1'b1;
              raddr = idx_q - IdxW'(1);
            end
          end else begin
            if (!at_limit) begin
              we    = 1'b1;
              waddr = IdxW'(idx_next);
              wdata = new_entry;
              cnt_d = cnt_after_put;
            end
            state_d = StIdle;
          end
        end
      end

      StInsPut: begin
        we      = 1'b1;
        waddr   = '0;
        wdata   = new_entry;
        cnt_d   = cnt_after_put;
        state_d = StIdle;
      end

      StList: begin
        if (out_free) begin
          out_load  = 1'b1;
          out_rsp_d.result_kind  = KindListed;
          out_rsp_d.out_tag      = rdata_q.tag;
          out_rsp_d.out_duration = rdata_q.dur;
          out_rsp_d.last_of_run  = (idx_next == cnt_q);
          if (idx_next == cnt_q) begin
            state_d = StIdle;
          end else begin
            idx_d = IdxW'(idx_next);
            rd_en = 1'b1;
            raddr = IdxW'(idx_next);
          end
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // limit write: zero acts as one, saturates at the depth
  always_comb begin
    cfg_v = CmpW'(cfg_data_i);
    if (cfg_v == '0) begin
      limit_d = CntW'(1);
    end else if (cfg_v > CmpW'(MAX_ENTRIES)) begin
      limit_d = CntW'(MAX_ENTRIES);
    end else begin
      limit_d = CntW'(cfg_v);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      limit_q     <= CntW'(MAX_ENTRIES);
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      if (cfg_we_i && (cnt_q == '0)) begin
        limit_q <= limit_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      new_tag_q <= in_req_i.record_tag;
      new_dur_q <= in_req_i.record_duration;
    end
    if (out_load) begin
      out_rsp_q <= out_rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

`default_nettype wire

// ===== hdl/stkt_checker.sv =====
// Port-level checker for the sorted top-k tracker, bound to the top level.
// Depends on stkt_pkg and sorted_top_k_tracker_macros.svh.
`default_nettype none

`include "sorted_top_k_tracker_macros.svh"

module stkt_checker
  import stkt_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire in_req_t            in_req_i,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire out_rsp_t           out_rsp_o,
  input wire logic               cfg_we_i,
  input wire logic [CfgBits-1:0] cfg_data_i
);

  logic shown_evict;
  logic shown_list_open;

  assign shown_evict     = out_valid_o && (out_rsp_o.result_kind == KindEvict);
  assign shown_list_open = out_valid_o && (out_rsp_o.result_kind == KindListed) &&
                           !out_rsp_o.last_of_run;

  // a stalled result holds
  `STKT_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))

  // an eviction is always the only result of its insert
  `STKT_ASSERT(a_evict_last, clk_i, rst_ni, shown_evict |-> out_rsp_o.last_of_run)

  // while a readout still has entries to show, the input side stays closed
  `STKT_ASSERT(a_list_busy, clk_i, rst_ni, shown_list_open |-> !in_ready_o)

  // nothing is shown straight after a reset cycle
  `STKT_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !out_valid_o)

endmodule

bind sorted_top_k_tracker stkt_checker u_stkt_checker (.*);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for sorted_top_k_tracker: directed and random requests checked
// against a shadow copy of the sorted list. Depends on stkt_pkg and the RTL.

module testbench;
  import stkt_pkg::*;

  localparam int unsigned Depth       = MaxEntriesDefault;
  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned Phases      = 6;
  localparam int unsigned PhaseLen    = 41;
  localparam logic [DurBits-1:0] DurMax = '1;
  localparam logic [TagBits-1:0] TagMax = '1;

  logic               clk_i     = 1'b0;
  logic               rst_ni    = 1'b0;
  logic               req_valid = 1'b0;
  logic               req_ready;
  in_req_t            req_data  = '0;
  logic               rsp_valid;
  logic               rsp_ready = 1'b0;
  out_rsp_t           rsp_data;
  logic               cfg_we    = 1'b0;
  logic [CfgBits-1:0] cfg_data  = '0;

  // Shadow of the block's list and limit
  entry_t      shadow_list [Depth];
  int unsigned shadow_count = 0;
  int unsigned shadow_limit = Depth;
  out_rsp_t    results_due [$];

  bit          steady = 1'b0;  // no idling on either side
  int unsigned error_count    = 0;
  int unsigned requests_sent  = 0;
  int unsigned results_seen   = 0;
  int unsigned evictions_seen = 0;
  int unsigned listings_seen  = 0;
  int unsigned cycle_count    = 0;

  always #1 clk_i = ~clk_i;

  sorted_top_k_tracker #(
    .MAX_ENTRIES(Depth)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_valid),
    .in_ready_o  (req_ready),
    .in_req_i    (req_data),
    .out_valid_o (rsp_valid),
    .out_ready_i (rsp_ready),
    .out_rsp_o   (rsp_data),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data)
  );

  function automatic int unsigned draw_gap();
    if (steady) return 0;
    return $urandom_range(0, 13);
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  function automatic void track_limit_write(logic [CfgBits-1:0] v);
    int unsigned lim;
    lim = 32'(v);
    if (shadow_count != 0) return;  // locked once anything is held
    if (lim == 0) lim = 1;
    if (lim > Depth) lim = Depth;
    shadow_limit = lim;
  endfunction

  function automatic void place_entry(int unsigned pos, in_req_t r);
    shadow_list[pos].tag = r.record_tag;
    shadow_list[pos].dur = r.record_duration;
  endfunction

  // Applies one accepted request to the shadow list, queuing its results
  function automatic void track_request(in_req_t r);
    int unsigned pos;
    bit          found;
    out_rsp_t    res;
    pos   = shadow_count;
    found = 1'b0;
    if (r.op == OpList) begin
      for (int unsigned i = 0; i < shadow_count; i++) begin
        res.result_kind  = KindListed;
        res.out_tag      = shadow_list[i].tag;
        res.out_duration = shadow_list[i].dur;
        res.last_of_run  = (i + 1 == shadow_count);
        results_due.insert(results_due.size(), res);
      end
      return;
    end
    // first entry strictly shorter; ties stay ahead of the newcomer
    for (int unsigned i = 0; i < shadow_count; i++) begin
      if (!found && shadow_list[i].dur < r.record_duration) begin
        pos   = i;
        found = 1'b1;
      end
    end
    if (shadow_count < shadow_limit) begin
      for (int unsigned i = shadow_count; i > pos; i--) shadow_list[i] = shadow_list[i-1];
      place_entry(pos, r);
      shadow_count++;
      return;
    end
    res.result_kind = KindEvict;
    res.last_of_run = 1'b1;
    if (pos >= shadow_count) begin
      res.out_tag      = r.record_tag;
      res.out_duration = r.record_duration;
      results_due.insert(results_due.size(), res);
      return;
    end
    res.out_tag      = shadow_list[shadow_count-1].tag;
    res.out_duration = shadow_list[shadow_count-1].dur;
    results_due.insert(results_due.size(), res);
    for (int unsigned i = shadow_count - 1; i > pos; i--) shadow_list[i] = shadow_list[i-1];
    place_entry(pos, r);
  endfunction

  function automatic in_req_t make_insert(logic [TagBits-1:0] tag, logic [DurBits-1:0] dur);
    in_req_t r;
    r.op              = OpInsert;
    r.record_tag      = tag;
    r.record_duration = dur;
    return r;
  endfunction

  // tag and duration carry noise: a readout must ignore them
  function automatic in_req_t make_readout();
    in_req_t r;
    r.op              = OpList;
    r.record_tag      = $urandom;
    r.record_duration = DurBits'({$urandom, $urandom});
    return r;
  endfunction

  function automatic logic [DurBits-1:0] random_duration();
    logic [DurBits-1:0] d;
    d = '0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: d = DurBits'($urandom_range(0, 15));
      4, 5, 6:    d = DurBits'({$urandom, $urandom});
      7:          d = DurMax;
      8:          d = '0;
      default: begin
        // copy a held duration to force a tie
        if (shadow_count != 0) d = shadow_list[$urandom_range(0, shadow_count - 1)].dur;
        else d = DurBits'({$urandom, $urandom});
      end
    endcase
    return d;
  endfunction

  task automatic send_request(in_req_t r);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    do @(posedge clk_i); while (!req_ready);
    track_request(r);
    requests_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_limit(logic [CfgBits-1:0] v);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    track_limit_write(v);
  endtask

  // Waits for every due result, then lets an insert still in the walk finish
  task automatic settle();
    req_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic test_limit_settings();
    write_limit(5'd31);  // saturates
    write_limit(5'd0);   // acts as one
    write_limit(5'd17);
    case ($urandom_range(0, 4))
      0:       write_limit(5'd0);
      1:       write_limit(5'd16);
      2:       write_limit(5'd31);
      default: write_limit(5'($urandom_range(2, 15)));
    endcase
  endtask

  task automatic test_empty_readout();
    send_request(make_readout());
    settle();
  endtask

  task automatic test_directed_inserts();
    logic [DurBits-1:0] durs [18];
    logic [TagBits-1:0] tag;
    durs = '{DurMax, 0, 5, 5, 5, DurMax, 0, 100, 3, 7, 1, 2, 9, 50, 20, 11, 4, 6};
    for (int i = 0; i < 18; i++) begin
      if (i == 0) tag = TagMax;
      else if (i == 1) tag = '0;
      else tag = {16'h5A5A, 16'(i)};
      send_request(make_insert(tag, durs[i]));
    end
    send_request(make_readout());
    // a zero duration into a full list: the newcomer itself drops out
    send_request(make_insert(32'hC0DE_0001, '0));
    send_request(make_insert(32'hC0DE_0002, DurMax));
    send_request(make_readout());
    settle();
  endtask

  task automatic test_limit_locked();
    write_limit(shadow_limit == 1 ? 5'd16 : 5'd1);
    write_limit(5'd0);
  endtask

  task automatic test_random_traffic();
    in_req_t r;
    for (int unsigned p = 0; p < Phases; p++) begin
      steady = (p == 2);
      for (int unsigned n = 0; n < PhaseLen; n++) begin
        if ($urandom_range(0, 4) == 0) r = make_readout();
        else r = make_insert($urandom, random_duration());
        send_request(r);
      end
      settle();
      write_limit(5'($urandom));
    end
    steady = 1'b0;
  endtask

  // Result sink with random back-pressure
  initial begin : rsp_sink
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      gap = draw_gap();
      if (gap != 0) begin
        rsp_ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_valid);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin : rsp_check
    out_rsp_t want;
    if (rst_ni && rsp_valid && rsp_ready) begin
      results_seen++;
      if (rsp_data.result_kind == KindEvict) evictions_seen++;
      else listings_seen++;
      if (results_due.size() == 0) begin
        report_mismatch($sformatf("result with none due: tag %h duration %h",
                                  rsp_data.out_tag, rsp_data.out_duration));
      end else begin
        want = results_due.pop_front();
        if (rsp_data.result_kind !== want.result_kind)
          report_mismatch($sformatf("result_kind %b, wanted %b",
                                    rsp_data.result_kind, want.result_kind));
        if (rsp_data.out_tag !== want.out_tag)
          report_mismatch($sformatf("out_tag %h, wanted %h", rsp_data.out_tag, want.out_tag));
        if (rsp_data.out_duration !== want.out_duration)
          report_mismatch($sformatf("out_duration %h, wanted %h",
                                    rsp_data.out_duration, want.out_duration));
        if (rsp_data.last_of_run !== want.last_of_run)
          report_mismatch($sformatf("last_of_run %b, wanted %b",
                                    rsp_data.last_of_run, want.last_of_run));
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d results still due", cycle_count,
             results_due.size());
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_limit_settings();
    test_empty_readout();
    test_directed_inserts();
    test_limit_locked();
    test_random_traffic();
    settle();
    $display("Summary: %0d requests sent, %0d results checked (%0d evictions, %0d listed)",
             requests_sent, results_seen, evictions_seen, listings_seen);
    $display("Summary: keep limit %0d, %0d entries held at the end, %0d mismatches",
             shadow_limit, shadow_count, error_count);
    if (error_count == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

endmodule
